@@ hw/rtl/char_lcd_bus_sequencer_defines.svh @@
// Assertion macros for the LCD bus sequencer.
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define CLBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CLBS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/clbs_pkg.sv @@
package clbs_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
        logic       reg_select;
    } cmd_item_t;

    typedef struct packed {
        logic        strobe_res;
        logic        rs_level;
        logic [7:0]  bus_value;
        logic [16:0] wait_us;
        logic        last;
    } evt_item_t;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] REG_BUS_EIGHT  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SHORT_WAIT = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_LONG_WAIT  = 2'd2;

    localparam logic [9:0]  SHORT_WAIT_RESET = 10'd38;
    localparam logic [15:0] LONG_WAIT_RESET  = 16'd1520;

    localparam logic [16:0] POWER_WAIT_US  = 17'd15000;
    localparam logic [16:0] WAKE1_EXTRA_US = 17'd4100;
    localparam logic [16:0] WAKE2_EXTRA_US = 17'd100;

    localparam int PcWidth = 4;
    localparam logic [PcWidth-1:0] PC_SEND = 4'd0;
    localparam logic [PcWidth-1:0] PC_INIT = 4'd1;
    localparam logic [PcWidth-1:0] PC_LAST = 4'd11;

    typedef enum logic [2:0] {
        WS_POWER,
        WS_SHORT,
        WS_WAKE1,
        WS_WAKE2,
        WS_LONG,
        WS_COND_LONG
    } wait_sel_t;

    typedef enum logic [1:0] {
        M_ANY,
        M_FOUR,
        M_EIGHT
    } mode_sel_t;

    typedef struct packed {
        logic       strobe;
        logic       byte_op;
        logic       use_input;
        logic [7:0] data;
        wait_sel_t  wait_sel;
        mode_sel_t  mode;
        logic       last;
    } ucode_t;

    // strobe, byte_op, use_input, data, wait, mode, last
    function automatic ucode_t ucode_rom(input logic [PcWidth-1:0] pc);
        ucode_t w;
        unique case (pc)
            4'd0:    w = '{1'b1, 1'b1, 1'b1, 8'h00, WS_COND_LONG, M_ANY,   1'b1};
            4'd1:    w = '{1'b0, 1'b0, 1'b0, 8'h00, WS_POWER,     M_ANY,   1'b0};
            4'd2:    w = '{1'b1, 1'b0, 1'b0, 8'h30, WS_WAKE1,     M_ANY,   1'b0};
            4'd3:    w = '{1'b1, 1'b0, 1'b0, 8'h30, WS_WAKE2,     M_ANY,   1'b0};
            4'd4:    w = '{1'b1, 1'b0, 1'b0, 8'h30, WS_SHORT,     M_ANY,   1'b0};
            4'd5:    w = '{1'b1, 1'b0, 1'b0, 8'h20, WS_SHORT,     M_FOUR,  1'b0};
            4'd6:    w = '{1'b1, 1'b1, 1'b0, 8'h28, WS_SHORT,     M_FOUR,  1'b0};
            4'd7:    w = '{1'b1, 1'b1, 1'b0, 8'h38, WS_SHORT,     M_EIGHT, 1'b0};
            4'd8:    w = '{1'b1, 1'b1, 1'b0, 8'h08, WS_SHORT,     M_ANY,   1'b0};
            4'd9:    w = '{1'b1, 1'b1, 1'b0, 8'h01, WS_LONG,      M_ANY,   1'b0};
            4'd10:   w = '{1'b1, 1'b1, 1'b0, 8'h06, WS_SHORT,     M_ANY,   1'b0};
            4'd11:   w = '{1'b1, 1'b1, 1'b0, 8'h0C, WS_SHORT,     M_ANY,   1'b1};
            default: w = '{1'b0, 1'b0, 1'b0, 8'h00, WS_SHORT,     M_ANY,   1'b1};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/char_lcd_bus_sequencer.sv @@
// Channel | Direction | Handshake              | Item
// cmd     | in        | cmd_valid / cmd_ready  | cmd_item_t: func, byte_value, reg_select
// evt     | out       | evt_valid / evt_ready  | evt_item_t: one bus event
// cfg     | in        | cfg_write              | cfg_index, cfg_data
//
// A step counter walks a 12-word microcode table; each step emits at most one
// event per cycle into a single output register. A send emits one event (8-bit)
// or two nibble events (4-bit); init emits power wait, wake and setup events.
// One item is taken at a time; cmd_ready rises at the edge that registers the
// last event. The step counter holds while evt is stalled.
// Reset: idle, bus_eight_bits 0, short wait 38 us, long wait 1520 us.
`include "char_lcd_bus_sequencer_defines.svh"

module char_lcd_bus_sequencer
    import clbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  cmd_item_t                cmd,
    output logic                     evt_valid,
    input  logic                     evt_ready,
    output evt_item_t                evt,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic               eight_reg;
    logic [9:0]         short_reg;
    logic [15:0]        long_reg;

    logic               busy_reg, busy_next;
    logic [PcWidth-1:0] pc_reg, pc_next;
    logic               phase_reg, phase_next;
    logic               evt_valid_reg, evt_valid_next;
    evt_item_t          evt_reg, evt_next;
    logic [7:0]         byte_reg, byte_next;
    logic               rs_reg, rs_next;
    logic               cond_reg, cond_next;

    ucode_t             uw;
    logic               advance;
    logic               enabled;
    logic               split;
    logic               first_half;
    logic [7:0]         value;
    logic [16:0]        short_ext;
    logic [16:0]        extra;
    logic [16:0]        wait_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_reg <= 1'b0;
            short_reg <= SHORT_WAIT_RESET;
            long_reg  <= LONG_WAIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BUS_EIGHT:  eight_reg <= cfg_data[0];
                REG_SHORT_WAIT: short_reg <= cfg_data[9:0];
                REG_LONG_WAIT:  long_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign uw        = ucode_rom(pc_reg);
    assign advance   = busy_reg && (!evt_valid_reg || evt_ready);
    assign enabled   = (uw.mode == M_ANY) || ((uw.mode == M_FOUR) && !eight_reg)
                       || ((uw.mode == M_EIGHT) && eight_reg);
    assign split      = uw.byte_op && !eight_reg;
    assign first_half = split && !phase_reg;
    assign value      = uw.use_input ? byte_reg : uw.data;
    assign short_ext  = {7'd0, short_reg};

    always_comb
    begin
        extra = 17'd0;
        case (uw.wait_sel)
            WS_WAKE1:     extra = WAKE1_EXTRA_US;
            WS_WAKE2:     extra = WAKE2_EXTRA_US;
            WS_LONG:      extra = {1'b0, long_reg};
            WS_COND_LONG: extra = cond_reg ? {1'b0, long_reg} : 17'd0;
            default:      extra = 17'd0;
        endcase
        if (first_half)
        begin
            extra = 17'd0;
        end
        if (uw.wait_sel == WS_POWER)
        begin
            wait_val = POWER_WAIT_US;
        end
        else
        begin
            wait_val = short_ext + extra;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        phase_next     = phase_reg;
        evt_valid_next = evt_valid_reg;
        evt_next       = evt_reg;
        byte_next      = byte_reg;
        rs_next        = rs_reg;
        cond_next      = cond_reg;

        if (evt_valid_reg && evt_ready)
        begin
            evt_valid_next = 1'b0;
        end

        if (cmd_valid && !busy_reg)
        begin
            busy_next  = 1'b1;
            pc_next    = cmd.func ? PC_INIT : PC_SEND;
            phase_next = 1'b0;
            byte_next  = cmd.byte_value;
            rs_next    = cmd.reg_select;
            cond_next  = !cmd.reg_select && (cmd.byte_value[7:2] == 6'd0)
                         && (cmd.byte_value[1:0] != 2'd0);
        end

        if (advance)
        begin
            if (!enabled)
            begin
                pc_next = pc_reg + 4'd1;
            end
            else
            begin
                evt_valid_next      = 1'b1;
                evt_next.strobe_res = uw.strobe;
                evt_next.rs_level   = uw.strobe && uw.use_input && rs_reg;
                if (!uw.strobe)
                begin
                    evt_next.bus_value = 8'h00;
                end
                else if (split)
                begin
                    evt_next.bus_value = phase_reg ? {value[3:0], 4'h0}
                                                   : {value[7:4], 4'h0};
                end
                else
                begin
                    evt_next.bus_value = value;
                end
                evt_next.wait_us = wait_val;
                evt_next.last    = uw.last && !first_half;
                if (first_half)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (uw.last)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        pc_next = pc_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_SEND;
            phase_reg     <= 1'b0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg  <= evt_next;
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
        cond_reg <= cond_next;
    end

    assign cmd_ready = !busy_reg;
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    `CLBS_ASSERT_NOW(a_pc_range, clk, rst_n, busy_reg, pc_reg <= PC_LAST)
    `CLBS_ASSERT_NOW(a_phase_only_4bit, clk, rst_n, phase_reg, busy_reg && !eight_reg)
    `CLBS_ASSERT_NOW(a_wait_not_last, clk, rst_n, evt_valid && !evt.strobe_res, !evt.last)
    `CLBS_ASSERT_NEXT(a_half_then_second, clk, rst_n,
        advance && enabled && first_half, phase_reg && busy_reg)

endmodule
